[rtl/arep_pkg.sv]
// Package of the advertising report event parser.
// Holds the widths, the phase and kind codes and the command type shared
// by the front end, the command queue and the back end. No dependencies.
package arep_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 5;
    localparam int VAL_W      = 48;
    localparam int ADDR_BYTES = 6;
    localparam int Q_DEPTH    = 4;
    // Two banks of payload bytes, one position field each.
    localparam int RAM_AW     = POS_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;

    typedef enum logic [3:0] {
        PH_SUB,
        PH_COUNT,
        PH_ETYPE,
        PH_ATYPE,
        PH_ADDR,
        PH_DLEN,
        PH_DATA,
        PH_RSSI,
        PH_IGNORE
    } t_phase;

    typedef enum logic [2:0] {
        K_ETYPE = 3'd0,
        K_ATYPE = 3'd1,
        K_ADDR  = 3'd2,
        K_DLEN  = 3'd3,
        K_DATA  = 3'd4,
        K_RSSI  = 3'd5,
        K_DONE  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FIELD,
        B_RUN,
        B_DONE
    } t_bstate;

    // One queued command: an optional single field or a data run, then an
    // optional event done result.
    typedef struct packed {
        logic              field_en;
        t_kind             kind;
        logic [BYTE_W-1:0] report;
        logic [VAL_W-1:0]  value;
        logic              run_en;
        logic              bank;
        logic [POS_W-1:0]  run_len;
        logic              done_en;
        logic [BYTE_W-1:0] done_count;
    } t_cmd;

    typedef struct packed {
        logic run_done;
    } t_back_status;

endpackage

[rtl/arep_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// Standalone; used for the payload byte banks.
module arep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/arep_front.sv]
// Front end of the advertising report event parser: accepts event bytes,
// tracks the report layout and queues commands for the back end.
// Depends on arep_pkg.
module arep_front import arep_pkg::*; #(
    parameter int PAYLOAD_MAX = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BYTE_W-1:0]   i_event_byte,
    input  logic                i_end_of_event,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BYTE_W-1:0]   i_cfg_data,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_q_ready,
    output logic                o_ram_we,
    output logic [RAM_AW-1:0]   o_ram_waddr,
    output logic [BYTE_W-1:0]   o_ram_wdata,
    input  t_back_status        i_status
);

    localparam logic [BYTE_W-1:0] PMAX = BYTE_W'(PAYLOAD_MAX);

    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_limit, n_limit;
    logic [BYTE_W-1:0]  r_cur, n_cur;
    logic [VAL_W-1:0]   r_addr, n_addr;
    logic [POS_W-1:0]   r_cnt, n_cnt;
    logic [POS_W-1:0]   r_plen, n_plen;
    logic [BYTE_W-1:0]  r_max;
    logic               r_bank, n_bank;
    logic [1:0]         r_runs, n_runs;

    logic               accept;
    logic [BYTE_W-1:0]  lim_new;
    logic [POS_W-1:0]   plen_new;
    logic [POS_W-1:0]   cnt_inc;
    logic [BYTE_W-1:0]  cur_inc;
    logic [VAL_W-1:0]   addr_new;
    t_cmd               cmd;

    // Both banks hold runs not yet read out: no data byte may be written.
    assign o_ready     = i_q_ready && !(r_phase == PH_DATA && r_runs == 2'd2);
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign lim_new  = (i_event_byte > r_max) ? r_max : i_event_byte;
    assign plen_new = (i_event_byte > PMAX) ? PMAX[POS_W-1:0] : i_event_byte[POS_W-1:0];
    assign cnt_inc  = r_cnt + POS_W'(1);
    assign cur_inc  = r_cur + BYTE_W'(1);
    assign addr_new = {i_event_byte, r_addr[VAL_W-1:BYTE_W]};

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_end_of_event) begin
                n_phase = PH_SUB;
            end else begin
                unique case (r_phase)
                    PH_SUB:    n_phase = PH_COUNT;
                    PH_COUNT:  n_phase = (lim_new == '0) ? PH_IGNORE : PH_ETYPE;
                    PH_ETYPE:  n_phase = PH_ATYPE;
                    PH_ATYPE:  n_phase = PH_ADDR;
                    PH_ADDR: begin
                        if (cnt_inc >= POS_W'(ADDR_BYTES)) n_phase = PH_DLEN;
                    end
                    PH_DLEN:   n_phase = (plen_new == '0) ? PH_RSSI : PH_DATA;
                    PH_DATA: begin
                        if (cnt_inc >= r_plen) n_phase = PH_RSSI;
                    end
                    PH_RSSI:   n_phase = (cur_inc >= r_limit) ? PH_IGNORE : PH_ETYPE;
                    PH_IGNORE: n_phase = PH_IGNORE;
                    default:   n_phase = PH_IGNORE;
                endcase
            end
        end
    end

    always_comb begin
        n_limit        = r_limit;
        n_cur          = r_cur;
        n_addr         = r_addr;
        n_cnt          = r_cnt;
        n_plen         = r_plen;
        n_bank         = r_bank;
        cmd            = '0;
        cmd.kind       = K_ETYPE;
        cmd.report     = r_cur;
        cmd.bank       = r_bank;
        cmd.run_len    = r_plen;
        o_ram_we       = 1'b0;
        o_ram_waddr    = {r_bank, r_cnt};
        o_ram_wdata    = i_event_byte;
        if (accept) begin
            unique case (r_phase)
                PH_SUB: begin
                    n_limit = '0;
                    n_cur   = '0;
                end
                PH_COUNT: begin
                    n_limit = lim_new;
                    n_cur   = '0;
                end
                PH_ETYPE: begin
                    cmd.field_en = 1'b1;
                    cmd.kind     = K_ETYPE;
                    cmd.value    = VAL_W'(i_event_byte);
                end
                PH_ATYPE: begin
                    cmd.field_en = 1'b1;
                    cmd.kind     = K_ATYPE;
                    cmd.value    = VAL_W'(i_event_byte);
                    n_addr       = '0;
                    n_cnt        = '0;
                end
                PH_ADDR: begin
                    n_addr = addr_new;
                    n_cnt  = cnt_inc;
                    if (cnt_inc >= POS_W'(ADDR_BYTES)) begin
                        cmd.field_en = 1'b1;
                        cmd.kind     = K_ADDR;
                        cmd.value    = addr_new;
                        n_cnt        = '0;
                    end
                end
                PH_DLEN: begin
                    n_plen       = plen_new;
                    cmd.field_en = 1'b1;
                    cmd.kind     = K_DLEN;
                    cmd.value    = VAL_W'(plen_new);
                    n_cnt        = '0;
                end
                PH_DATA: begin
                    o_ram_we = 1'b1;
                    n_cnt    = cnt_inc;
                    if (cnt_inc >= r_plen) begin
                        cmd.run_en = 1'b1;
                        n_cnt      = '0;
                        n_bank     = ~r_bank;
                    end
                end
                PH_RSSI: begin
                    cmd.field_en = 1'b1;
                    cmd.kind     = K_RSSI;
                    cmd.value    = VAL_W'(i_event_byte);
                    n_cur        = cur_inc;
                end
                PH_IGNORE: begin
                end
                default: begin
                end
            endcase
            if (i_end_of_event) begin
                cmd.done_en    = 1'b1;
                cmd.done_count = n_limit;
                n_limit        = '0;
                n_cur          = '0;
                n_addr         = '0;
                n_cnt          = '0;
                n_plen         = '0;
            end
        end
    end

    assign o_push = accept && (cmd.field_en || cmd.run_en || cmd.done_en);
    assign o_cmd  = cmd;
    assign n_runs = r_runs + 2'(o_push && cmd.run_en) - 2'(i_status.run_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SUB;
            r_limit <= '0;
            r_cur   <= '0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_plen  <= '0;
            r_max   <= BYTE_W'(16);
            r_bank  <= 1'b0;
            r_runs  <= '0;
        end else begin
            r_phase <= n_phase;
            r_limit <= n_limit;
            r_cur   <= n_cur;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_plen  <= n_plen;
            r_bank  <= n_bank;
            r_runs  <= n_runs;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    a_runs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs <= 2'd2)
        else $error("more data runs outstanding than there are banks");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_q_ready)
        else $error("command pushed into a full queue");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_plen))
        else $error("payload position beyond the data length");

endmodule

[rtl/arep_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on arep_pkg for the command type and the queue depth.
module arep_fifo import arep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_valid
);

    localparam int QAW = $clog2(Q_DEPTH);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_ready = (r_count != (QAW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QAW'(1);
            if (i_pop)  r_rptr <= r_rptr + QAW'(1);
            r_count <= r_count + (QAW + 1)'(i_push) - (QAW + 1)'(i_pop);
        end
    end

endmodule

[rtl/arep_back.sv]
// Back end of the advertising report event parser: takes queued commands,
// reads buffered payload bytes and drives the registered result channel.
// Depends on arep_pkg.
module arep_back import arep_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_data,
    output logic                o_pop,
    output logic                o_ram_re,
    output logic [RAM_AW-1:0]   o_ram_raddr,
    input  logic [BYTE_W-1:0]   i_ram_rdata,
    output t_back_status        o_status,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_field_kind,
    output logic [BYTE_W-1:0]   o_report_number,
    output logic [POS_W-1:0]    o_byte_position,
    output logic [VAL_W-1:0]    o_field_value,
    output logic                o_last_of_run
);

    t_bstate            r_state, n_state;
    t_cmd               r_cmd;
    logic [POS_W-1:0]   r_pos;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [BYTE_W-1:0]  r_out_report;
    logic [POS_W-1:0]   r_out_pos;
    logic [VAL_W-1:0]   r_out_value;
    logic               r_out_last;

    logic               slot_free;
    logic               run_last;
    logic               load;
    t_kind              ld_kind;
    logic [BYTE_W-1:0]  ld_report;
    logic [POS_W-1:0]   ld_pos;
    logic [VAL_W-1:0]   ld_value;
    logic               ld_last;
    logic               step_pos;

    assign slot_free = !r_out_valid || i_ready;
    assign run_last  = (r_pos == r_cmd.run_len - POS_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_data.field_en)    n_state = B_FIELD;
                    else if (i_q_data.run_en) n_state = B_RUN;
                    else                      n_state = B_DONE;
                end
            end
            B_FIELD: begin
                if (slot_free) n_state = r_cmd.done_en ? B_DONE : B_IDLE;
            end
            B_RUN: begin
                if (slot_free && run_last) n_state = r_cmd.done_en ? B_DONE : B_IDLE;
            end
            B_DONE: begin
                if (slot_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // The RAM read for the next payload byte is issued together with the
    // load of the current one, so a run leaves at one byte per cycle while the output register is free.
    always_comb begin
        o_pop             = 1'b0;
        o_ram_re          = 1'b0;
        o_ram_raddr       = {r_cmd.bank, r_pos + POS_W'(1)};
        o_status.run_done = 1'b0;
        load              = 1'b0;
        step_pos          = 1'b0;
        ld_kind           = K_DONE;
        ld_report         = '0;
        ld_pos            = '0;
        ld_value          = VAL_W'(r_cmd.done_count);
        ld_last           = 1'b1;
        unique case (r_state)
            B_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid && i_q_data.run_en) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = {i_q_data.bank, POS_W'(0)};
                end
            end
            B_FIELD: begin
                load      = slot_free;
                ld_kind   = r_cmd.kind;
                ld_report = r_cmd.report;
                ld_value  = r_cmd.value;
                ld_last   = !r_cmd.done_en;
            end
            B_RUN: begin
                load              = slot_free;
                ld_kind           = K_DATA;
                ld_report         = r_cmd.report;
                ld_pos            = r_pos;
                ld_value          = VAL_W'(i_ram_rdata);
                ld_last           = run_last && !r_cmd.done_en;
                o_ram_re          = slot_free && !run_last;
                step_pos          = slot_free && !run_last;
                o_status.run_done = slot_free && run_last;
            end
            B_DONE: begin
                load = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_data;
        end
        if (o_pop) begin
            r_pos <= '0;
        end else if (step_pos) begin
            r_pos <= r_pos + POS_W'(1);
        end
        if (load) begin
            r_out_kind   <= ld_kind;
            r_out_report <= ld_report;
            r_out_pos    <= ld_pos;
            r_out_value  <= ld_value;
            r_out_last   <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_field_kind    = r_out_kind;
    assign o_report_number = r_out_report;
    assign o_byte_position = r_out_pos;
    assign o_field_value   = r_out_value;
    assign o_last_of_run   = r_out_last;

    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN) |-> (r_cmd.run_en && r_pos < r_cmd.run_len))
        else $error("payload read outside the queued run");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE && slot_free) |=>
            (o_valid && o_last_of_run && o_field_kind == K_DONE))
        else $error("event done result not presented as the last of its run");

endmodule

[rtl/adv_report_event_parser.sv]
// Advertising report event parser, top level.
// Instantiates the front end, the command queue, the payload RAM and the
// back end; depends on arep_pkg.
//
// Usage: event bytes enter one per transfer on i_valid/o_ready, with
// i_end_of_event set on the final byte of an event. Results leave one per
// transfer on o_valid/i_ready; o_last_of_run marks the final result caused
// by one input byte. The report limit is written on i_cfg_valid/o_cfg_ready,
// which is always ready; the user must write it only while the block is
// idle, as the block itself does not enforce this. A field result passes
// the command queue, the back end's command register and the output
// register. Throughput: the front end takes one byte per cycle while the
// four-entry command queue has room; the back end takes a new command only
// once it has loaded every result of the last one. Payload bytes go to one
// of two RAM banks; a byte of a third data run waits until the oldest run
// has been read out. Reset clears the parse state, the queue and the output
// register and sets the report limit to 16; the payload RAM needs no
// clearing. When the receiver stalls, the output register holds, the queue
// fills and o_ready falls.
module adv_report_event_parser import arep_pkg::*; #(
    parameter int PAYLOAD_MAX = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BYTE_W-1:0]   i_event_byte,
    input  logic                i_end_of_event,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BYTE_W-1:0]   i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_field_kind,
    output logic [BYTE_W-1:0]   o_report_number,
    output logic [POS_W-1:0]    o_byte_position,
    output logic [VAL_W-1:0]    o_field_value,
    output logic                o_last_of_run
);

    logic               push;
    t_cmd               push_cmd;
    logic               q_ready;
    logic               pop;
    t_cmd               head_cmd;
    logic               q_valid;
    logic               ram_we;
    logic [RAM_AW-1:0]  ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;
    t_back_status       back_status;

    arep_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_event_byte   (i_event_byte),
        .i_end_of_event (i_end_of_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_q_ready      (q_ready),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .i_status       (back_status)
    );

    arep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_valid (q_valid)
    );

    arep_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    arep_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (head_cmd),
        .o_pop           (pop),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_status        (back_status),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_field_kind    (o_field_kind),
        .o_report_number (o_report_number),
        .o_byte_position (o_byte_position),
        .o_field_value   (o_field_value),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench of adv_report_event_parser: a directed script, then random
// advertising report events, checked against a cycle-free predictor of the parser.
// Depends on arep_pkg and the parser RTL only.
module testbench import arep_pkg::*; ();

    localparam int PAYLOAD_MAX = 31;
    localparam int HALF_PERIOD = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTED_ERRORS = 10;
    localparam int SCRIPT_ROWS = 27;

    typedef struct {
        t_kind       kind;
        logic [7:0]  report;
        logic [4:0]  pos;
        logic [47:0] value;
        logic        last;
    } t_field_result;

    typedef struct {
        logic [7:0] data;
        logic       eoe;
    } t_event_byte;

    typedef struct {
        logic [7:0]  data;
        logic        eoe;
        logic        fixed_exp;
        t_kind       kind;
        logic [7:0]  report;
        logic [47:0] value;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_event_byte = 8'd0;
    logic        i_end_of_event = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic [2:0]  o_field_kind;
    logic [7:0]  o_report_number;
    logic [4:0]  o_byte_position;
    logic [47:0] o_field_value;
    logic        o_last_of_run;

    // Predictor state
    logic [7:0]  max_rep = 8'd16;
    t_phase      phase = PH_SUB;
    logic [7:0]  rep_limit = 8'd0;
    logic [7:0]  cur_rep = 8'd0;
    logic [47:0] addr_shift = 48'd0;
    int          field_bytes = 0;
    logic [4:0]  pay_len = 5'd0;
    logic [7:0]  data_buf [0:PAYLOAD_MAX-1];

    t_field_result step_fields[$];
    t_field_result pending_fields[$];
    t_event_byte   event_bytes[$];

    bit idle_on = 1'b0;
    int gap_odds = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int n_errors = 0;
    int n_bytes = 0;
    int n_events = 0;
    int n_results = 0;
    int n_cfg = 0;

    // Directed script: event ending on its sub-event byte, an event with count zero and
    // extra bytes, then two reports at the field extremes, the second cut short in its data.
    t_script_row event_script [0:SCRIPT_ROWS-1] = '{
        '{8'h3E, 1'b1, 1'b1, K_DONE,  8'd0, 48'd0},
        '{8'h3E, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h00, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h55, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hAA, 1'b1, 1'b1, K_DONE,  8'd0, 48'd0},
        '{8'h3E, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h00, 1'b0, 1'b1, K_ETYPE, 8'd0, 48'h00},
        '{8'hFF, 1'b0, 1'b1, K_ATYPE, 8'd0, 48'hFF},
        '{8'h11, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h22, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h33, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h44, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h55, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'h66, 1'b0, 1'b1, K_ADDR,  8'd0, 48'h6655_4433_2211},
        '{8'h00, 1'b0, 1'b1, K_DLEN,  8'd0, 48'd0},
        '{8'h80, 1'b0, 1'b1, K_RSSI,  8'd0, 48'h80},
        '{8'hFF, 1'b0, 1'b1, K_ETYPE, 8'd1, 48'hFF},
        '{8'h00, 1'b0, 1'b1, K_ATYPE, 8'd1, 48'h00},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b0, K_ETYPE, 8'd0, 48'd0},
        '{8'hFF, 1'b0, 1'b1, K_ADDR,  8'd1, 48'hFFFF_FFFF_FFFF},
        '{8'h20, 1'b0, 1'b1, K_DLEN,  8'd1, 48'd31},
        '{8'hC3, 1'b1, 1'b1, K_DONE,  8'd0, 48'd16}
    };

    adv_report_event_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_event_byte   (i_event_byte),
        .i_end_of_event (i_end_of_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_kind   (o_field_kind),
        .o_report_number(o_report_number),
        .o_byte_position(o_byte_position),
        .o_field_value  (o_field_value),
        .o_last_of_run  (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void add_field(t_kind kind, logic [7:0] report, logic [4:0] pos,
                                      logic [47:0] value);
        step_fields.push_back('{kind, report, pos, value, 1'b0});
    endfunction

    // Works out the fields that one event byte completes, in the order they leave.
    function automatic void parse_byte(logic [7:0] b, logic eoe);
        step_fields.delete();
        case (phase)
            PH_SUB: begin
                rep_limit = 8'd0;
                cur_rep = 8'd0;
                phase = PH_COUNT;
            end
            PH_COUNT: begin
                rep_limit = (b > max_rep) ? max_rep : b;
                cur_rep = 8'd0;
                phase = (rep_limit == 8'd0) ? PH_IGNORE : PH_ETYPE;
            end
            PH_ETYPE: begin
                add_field(K_ETYPE, cur_rep, 5'd0, {40'd0, b});
                phase = PH_ATYPE;
            end
            PH_ATYPE: begin
                add_field(K_ATYPE, cur_rep, 5'd0, {40'd0, b});
                addr_shift = 48'd0;
                field_bytes = 0;
                phase = PH_ADDR;
            end
            PH_ADDR: begin
                // Little endian: each new byte enters at the top and moves down.
                addr_shift = {b, addr_shift[47:8]};
                field_bytes++;
                if (field_bytes >= ADDR_BYTES) begin
                    add_field(K_ADDR, cur_rep, 5'd0, addr_shift);
                    field_bytes = 0;
                    phase = PH_DLEN;
                end
            end
            PH_DLEN: begin
                pay_len = (b > PAYLOAD_MAX) ? 5'(PAYLOAD_MAX) : b[4:0];
                add_field(K_DLEN, cur_rep, 5'd0, {43'd0, pay_len});
                field_bytes = 0;
                phase = (pay_len == 5'd0) ? PH_RSSI : PH_DATA;
            end
            PH_DATA: begin
                if (field_bytes < PAYLOAD_MAX)
                    data_buf[field_bytes] = b;
                field_bytes++;
                if (field_bytes >= pay_len || field_bytes >= PAYLOAD_MAX) begin
                    for (int i = 0; i < pay_len; i++)
                        add_field(K_DATA, cur_rep, 5'(i), {40'd0, data_buf[i]});
                    field_bytes = 0;
                    phase = PH_RSSI;
                end
            end
            PH_RSSI: begin
                add_field(K_RSSI, cur_rep, 5'd0, {40'd0, b});
                cur_rep = cur_rep + 8'd1;
                phase = (cur_rep >= rep_limit) ? PH_IGNORE : PH_ETYPE;
            end
            default: begin
                phase = PH_IGNORE;
            end
        endcase
        if (eoe) begin
            add_field(K_DONE, 8'd0, 5'd0, {40'd0, rep_limit});
            phase = PH_SUB;
            rep_limit = 8'd0;
            cur_rep = 8'd0;
            addr_shift = 48'd0;
            field_bytes = 0;
            pay_len = 5'd0;
        end
        if (step_fields.size() > 0)
            step_fields[step_fields.size()-1].last = 1'b1;
    endfunction

    // Drives one byte, holding it until its transfer, and runs the predictor on it.
    task automatic send_byte(logic [7:0] b, logic eoe);
        if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_event_byte <= b;
        i_end_of_event <= eoe;
        do @(posedge i_clk); while (!o_ready);
        parse_byte(b, eoe);
        n_bytes++;
        if (eoe)
            n_events++;
    endtask

    task automatic write_max_reports(logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_rep = value;
        n_cfg++;
    endtask

    // Waits until every expected field has arrived, then lets trailing bytes drain.
    task automatic settle();
        while (pending_fields.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds one event: mostly well-formed reports with random content, some noise,
    // and now and then a cut short.
    task automatic build_event();
        int n_rep;
        int dlen;
        int cut;
        event_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) event_bytes.push_back('{8'($urandom), 1'b0});
        end else begin
            event_bytes.push_back('{8'($urandom), 1'b0});
            case ($urandom_range(0, 9))
                0: n_rep = 0;
                1: n_rep = $urandom_range(5, 255);
                default: n_rep = $urandom_range(1, 3);
            endcase
            event_bytes.push_back('{8'(n_rep), 1'b0});
            for (int r = 0; r < n_rep && r < 5; r++) begin
                repeat (2 + ADDR_BYTES) event_bytes.push_back('{8'($urandom), 1'b0});
                case ($urandom_range(0, 9))
                    0: dlen = 0;
                    1: dlen = PAYLOAD_MAX;
                    2: dlen = $urandom_range(PAYLOAD_MAX + 1, 255);
                    default: dlen = $urandom_range(1, 6);
                endcase
                event_bytes.push_back('{8'(dlen), 1'b0});
                repeat ((dlen > PAYLOAD_MAX) ? PAYLOAD_MAX : dlen)
                    event_bytes.push_back('{8'($urandom), 1'b0});
                event_bytes.push_back('{8'($urandom), 1'b0});
            end
            repeat ($urandom_range(0, 2)) event_bytes.push_back('{8'($urandom), 1'b0});
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, event_bytes.size());
                while (event_bytes.size() > cut) void'(event_bytes.pop_back());
            end
        end
        event_bytes[event_bytes.size()-1].eoe = 1'b1;
    endtask

    task automatic run_random(int quota);
        int sent;
        sent = 0;
        while (sent < quota) begin
            build_event();
            // The last event of a part is cut short if it is too long, so that the part meets its quota.
            if (event_bytes.size() > quota - sent) begin
                while (event_bytes.size() > quota - sent) void'(event_bytes.pop_back());
                event_bytes[event_bytes.size()-1].eoe = 1'b1;
            end
            gap_odds = (idle_on && $urandom_range(0, 3) != 0) ? 4 : 0;
            foreach (event_bytes[k]) begin
                send_byte(event_bytes[k].data, event_bytes[k].eoe);
                foreach (step_fields[j]) pending_fields.push_back(step_fields[j]);
            end
            sent += event_bytes.size();
        end
        i_valid <= 1'b0;
    endtask

    // Receiver side: drops i_ready in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_field_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_fields.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTED_ERRORS)
                    $display("unexpected result: kind %0d report %0d pos %0d value %h last %b",
                             o_field_kind, o_report_number, o_byte_position, o_field_value,
                             o_last_of_run);
            end else begin
                want = pending_fields.pop_front();
                if (o_field_kind !== want.kind || o_report_number !== want.report ||
                    o_byte_position !== want.pos || o_field_value !== want.value ||
                    o_last_of_run !== want.last) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTED_ERRORS) begin
                        $display("mismatch: expected kind %0d report %0d pos %0d value %h last %b",
                                 want.kind, want.report, want.pos, want.value, want.last);
                        $display("          got kind %0d report %0d pos %0d value %h last %b",
                                 o_field_kind, o_report_number, o_byte_position,
                                 o_field_value, o_last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_fields.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset limit of 16 reports.
        gap_odds = 0;
        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            send_byte(event_script[k].data, event_script[k].eoe);
            if (event_script[k].fixed_exp)
                pending_fields.push_back('{event_script[k].kind, event_script[k].report,
                                           5'd0, event_script[k].value, 1'b1});
            else
                foreach (step_fields[j]) pending_fields.push_back(step_fields[j]);
        end
        i_valid <= 1'b0;
        settle();

        idle_on = 1'b1;
        write_max_reports(8'd255);
        run_random(80);
        settle();
        write_max_reports(8'd0);
        run_random(25);
        settle();
        write_max_reports(8'd1);
        run_random(80);
        settle();
        write_max_reports(8'd2);
        run_random(80);
        settle();
        write_max_reports(8'($urandom_range(3, 254)));
        run_random(80);
        settle();

        // Last part at full rate on both sides.
        idle_on = 1'b0;
        write_max_reports(8'd16);
        run_random(100);
        settle();

        $display("summary: %0d event bytes in %0d events, %0d results checked, %0d limit writes",
                 n_bytes, n_events, n_results, n_cfg);
        if (n_errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
